// ===== src/scl_pkg.sv =====
// ----------------------------------------------------------------------------
// scl_pkg
// Shared types and constants for the shell command lexer: lexer modes,
// token kinds, result and queue entry records, character codes.
// ----------------------------------------------------------------------------
package scl_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_GT   = 2'd1,
        MODE_AMP  = 2'd2,
        MODE_WORD = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        KIND_WORD   = 3'd0,
        KIND_PIPE   = 3'd1,
        KIND_IN     = 3'd2,
        KIND_OUT    = 3'd3,
        KIND_APPEND = 3'd4,
        KIND_AND    = 3'd5,
        KIND_SEMI   = 3'd6,
        KIND_END    = 3'd7
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  ch;
        logic        last;
    } result_t;

    // One queue entry holds every result that one input byte causes.
    typedef struct packed {
        logic    two;
        result_t first;
        result_t second;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t data;
    } push_t;

    localparam int QDepth  = 4;
    localparam int QAddrW  = $clog2(QDepth);
    localparam int QCountW = $clog2(QDepth + 1);

    localparam logic [7:0] CharPipe  = 8'h7C;
    localparam logic [7:0] CharLt    = 8'h3C;
    localparam logic [7:0] CharGt    = 8'h3E;
    localparam logic [7:0] CharAmp   = 8'h26;
    localparam logic [7:0] CharSemi  = 8'h3B;
    localparam logic [7:0] CharUnder = 8'h5F;
    localparam logic [7:0] CharDash  = 8'h2D;
    localparam logic [7:0] CharDot   = 8'h2E;
    localparam logic [7:0] CharSlash = 8'h2F;
    localparam logic [7:0] CharEq    = 8'h3D;
    localparam logic [7:0] CharTilde = 8'h7E;

endpackage

// ===== src/scl_front.sv =====
// ----------------------------------------------------------------------------
// scl_front
// Accepts command line bytes, classifies each one against the lookahead
// mode and turns it into zero, one or two results for the queue.
// ----------------------------------------------------------------------------
module scl_front
    import scl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] text_byte,
    input  logic       end_of_line,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       q_full,
    output push_t      push
);

    mode_t      mode_reg, mode_next;
    logic [7:0] held_reg, held_next;

    logic    accept;
    logic    idle_v;
    result_t idle_r;
    mode_t   idle_mode;
    logic [7:0] idle_held;
    logic    pre_v;
    result_t pre_r;
    logic    use_idle;

    function automatic logic is_word_start(input logic [7:0] c);
        logic alnum;
        alnum = c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
        return alnum || c == CharUnder || c == CharDash || c == CharDot
            || c == CharSlash;
    endfunction

    function automatic logic is_word_cont(input logic [7:0] c);
        return is_word_start(c) || c == CharEq || c == CharTilde;
    endfunction

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Byte handled as if the lexer were idle.
    always_comb
    begin
        idle_v    = 1'b0;
        idle_r    = '{kind: KIND_END, ch: 8'h00, last: 1'b1};
        idle_mode = MODE_IDLE;
        idle_held = 8'h00;
        if (text_byte == CharPipe)
        begin
            idle_v      = 1'b1;
            idle_r.kind = KIND_PIPE;
        end
        else if (text_byte == CharLt)
        begin
            idle_v      = 1'b1;
            idle_r.kind = KIND_IN;
        end
        else if (text_byte == CharSemi)
        begin
            idle_v      = 1'b1;
            idle_r.kind = KIND_SEMI;
        end
        else if (text_byte == CharGt)
        begin
            idle_mode = MODE_GT;
        end
        else if (text_byte == CharAmp)
        begin
            idle_mode = MODE_AMP;
        end
        else if (is_word_start(text_byte))
        begin
            idle_mode = MODE_WORD;
            idle_held = text_byte;
        end
    end

    // Lookahead resolution: an optional leading result, then maybe the idle path.
    always_comb
    begin
        pre_v     = 1'b0;
        pre_r     = '{kind: KIND_END, ch: 8'h00, last: 1'b1};
        use_idle  = 1'b0;
        mode_next = mode_reg;
        held_next = held_reg;
        if (end_of_line)
        begin
            mode_next = MODE_IDLE;
            held_next = 8'h00;
            case (mode_reg)
                MODE_GT:
                begin
                    pre_v      = 1'b1;
                    pre_r.kind = KIND_OUT;
                end
                MODE_WORD:
                begin
                    pre_v = 1'b1;
                    pre_r = '{kind: KIND_WORD, ch: held_reg, last: 1'b1};
                end
                default:
                begin
                    pre_v = 1'b0;
                end
            endcase
        end
        else
        begin
            case (mode_reg)
                MODE_GT:
                begin
                    pre_v = 1'b1;
                    if (text_byte == CharGt)
                    begin
                        pre_r.kind = KIND_APPEND;
                        mode_next  = MODE_IDLE;
                    end
                    else
                    begin
                        pre_r.kind = KIND_OUT;
                        use_idle   = 1'b1;
                    end
                end
                MODE_AMP:
                begin
                    if (text_byte == CharAmp)
                    begin
                        pre_v      = 1'b1;
                        pre_r.kind = KIND_AND;
                        mode_next  = MODE_IDLE;
                    end
                    else
                    begin
                        use_idle = 1'b1;
                    end
                end
                MODE_WORD:
                begin
                    pre_v = 1'b1;
                    if (is_word_cont(text_byte))
                    begin
                        pre_r     = '{kind: KIND_WORD, ch: held_reg, last: 1'b0};
                        held_next = text_byte;
                    end
                    else
                    begin
                        pre_r    = '{kind: KIND_WORD, ch: held_reg, last: 1'b1};
                        use_idle = 1'b1;
                    end
                end
                default:
                begin
                    use_idle = 1'b1;
                end
            endcase
            if (use_idle)
            begin
                mode_next = idle_mode;
                held_next = idle_held;
            end
        end
    end

    // Pack the results of this byte into one queue entry.
    always_comb
    begin
        push.valid       = 1'b0;
        push.data.two    = 1'b0;
        push.data.first  = pre_r;
        push.data.second = '{kind: KIND_END, ch: 8'h00, last: 1'b1};
        if (end_of_line)
        begin
            push.valid = accept;
            if (pre_v)
            begin
                push.data.two = 1'b1;
            end
            else
            begin
                push.data.first = push.data.second;
            end
        end
        else if (pre_v)
        begin
            push.valid = accept;
            if (use_idle && idle_v)
            begin
                push.data.two    = 1'b1;
                push.data.second = idle_r;
            end
        end
        else if (use_idle && idle_v)
        begin
            push.valid      = accept;
            push.data.first = idle_r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            held_reg <= 8'h00;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            held_reg <= held_next;
        end
    end

endmodule

// ===== src/scl_queue.sv =====
// ----------------------------------------------------------------------------
// scl_queue
// Short first-in first-out queue of per-byte result entries between the
// classifying front and the emitting back.
// ----------------------------------------------------------------------------
module scl_queue
    import scl_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  push_t  push,
    output logic   full,
    input  logic   pop,
    output logic   empty,
    output entry_t head
);

    entry_t             entries_reg [QDepth];
    logic [QAddrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QAddrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCountW-1:0] count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == QCountW'(QDepth));
    assign empty   = (count_reg == '0);
    assign head    = entries_reg[rd_ptr_reg];
    assign do_push = push.valid && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAddrW'(QDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAddrW'(QDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/scl_back.sv =====
// ----------------------------------------------------------------------------
// scl_back
// Takes entries from the queue and hands out their results one per
// request through an output register, holding a second result aside.
// ----------------------------------------------------------------------------
module scl_back
    import scl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  entry_t     q_head,
    output logic       q_pop,
    output logic [2:0] token_kind,
    output logic [7:0] word_char,
    output logic       token_last,
    output logic       out_valid,
    input  logic       out_ready
);

    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;
    logic    pend_valid_reg, pend_valid_next;
    result_t pend_reg, pend_next;
    logic    load_en;

    assign load_en = !out_valid_reg || out_ready;
    assign q_pop   = load_en && !pend_valid_reg && !q_empty;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (load_en)
        begin
            if (pend_valid_reg)
            begin
                // Drain the held second result before the next entry.
                out_valid_next  = 1'b1;
                out_next        = pend_reg;
                pend_valid_next = 1'b0;
            end
            else if (!q_empty)
            begin
                out_valid_next  = 1'b1;
                out_next        = q_head.first;
                pend_valid_next = q_head.two;
                pend_next       = q_head.second;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign token_kind = out_reg.kind;
    assign word_char  = out_reg.ch;
    assign token_last = out_reg.last;

endmodule

// ===== src/shell_command_lexer.sv =====
// ----------------------------------------------------------------------------
// shell_command_lexer
// Streaming tokenizer for a shell command line.
// ----------------------------------------------------------------------------
// The lexer takes one byte per cycle while the queue is not full and emits
// one result per cycle while out_ready is high. A byte gives zero, one or
// two results (a pending '>' or word end plus a new token, or a flush plus
// END at end of line); these sit in a four-entry queue, so input stalls
// only when the queue is full, and the sustained rate is limited by the
// single output register, which a byte with two results uses twice. A
// byte's first result passes a queue entry, then the output register. Words
// stream one character per result, the final one with token_last set, and
// a word character lags one byte; the next byte tells if it ends the word.
// ----------------------------------------------------------------------------
module shell_command_lexer
    import scl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] text_byte,
    input  logic       end_of_line,
    input  logic       in_valid,
    output logic       in_ready,
    output logic [2:0] token_kind,
    output logic [7:0] word_char,
    output logic       token_last,
    output logic       out_valid,
    input  logic       out_ready
);

    push_t  push;
    logic   q_full;
    logic   q_empty;
    logic   q_pop;
    entry_t q_head;

    scl_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_byte   (text_byte),
        .end_of_line (end_of_line),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .q_full      (q_full),
        .push        (push)
    );

    scl_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .pop   (q_pop),
        .empty (q_empty),
        .head  (q_head)
    );

    scl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .token_kind (token_kind),
        .word_char  (word_char),
        .token_last (token_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready)
    );

endmodule

// ===== src/scl_checker.sv =====
// ----------------------------------------------------------------------------
// scl_checker
// Port-level checks for the shell command lexer, bound to the top level.
// ----------------------------------------------------------------------------
module scl_checker
    import scl_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic [2:0] token_kind,
    input logic [7:0] word_char,
    input logic       token_last,
    input logic       out_valid,
    input logic       out_ready
);

    // Hold a stalled request unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(token_kind)
            && $stable(word_char) && $stable(token_last))
    else $error("stalled result changed");

    // Operator and end tokens are single results with no character.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind != KIND_WORD |-> token_last && word_char == 8'h00)
    else $error("non-word token with character or without last");

    // Word characters come only from the word character set, never zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == KIND_WORD |-> word_char != 8'h00 && !word_char[7])
    else $error("word result with invalid character");

endmodule

bind shell_command_lexer scl_checker u_scl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .token_kind (token_kind),
    .word_char  (word_char),
    .token_last (token_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
);
